// ===== sv/qft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_pkg
// types, codes and helpers shared by the frame transform and its checker
// ----------------------------------------------------------------------------
package qft_pkg;

	localparam int unsigned ModeW = 3;
	localparam int unsigned DataW = 32;
	localparam int unsigned InTdataW = 136;
	localparam int unsigned OutTdataW = 128;

	typedef enum logic [ModeW-1:0] {
		MODE_SET_ORIENT  = 3'd0,
		MODE_SET_ORIGIN  = 3'd1,
		MODE_ROTATE      = 3'd2,
		MODE_TRANSLATE   = 3'd3,
		MODE_TO_LOCAL    = 3'd4,
		MODE_TO_GLOBAL   = 3'd5,
		MODE_READ_ORIENT = 3'd6,
		MODE_READ_ORIGIN = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HAM,
		ST_HAM_WB,
		ST_AXIS,
		ST_AXIS_WB,
		ST_VEC,
		ST_VEC_WB,
		ST_OUT
	} state_t;

	localparam logic signed [DataW-1:0] OneQ30 = 32'sh4000_0000;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [40:0] v);
		logic signed [DataW-1:0] r;
		if (v > 41'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -41'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[DataW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/quaternion_frame_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_frame_transform
// coordinate frame: orientation quaternion, origin and derived axis matrix
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// s_axis   in   mode, op_w, op_x, op_y, op_z
// m_axis   out  res_w, res_x, res_y, res_z
//
// one shared 32x32 multiplier, one product per cycle, accumulated per entry
// set_origin, translate: applied at the accept; read: result loaded in the out state
// set_orient: 21 axis terms, then write back; rotate: 16 hamilton terms and their write back first
// to_local and to_global: dot products with the axis matrix, result held in an output register
// a new word is taken only when idle and the output register is empty
// arst_n resets to the identity frame at zero origin
module quaternion_frame_transform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [qft_pkg::InTdataW-1:0]  s_axis_tdata,   // mode[2:0], op_w, op_x, op_y, op_z
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [qft_pkg::OutTdataW-1:0] m_axis_tdata    // res_w, res_x, res_y, res_z
);

	qft_pkg::state_t state_q, state_d;

	logic signed [31:0] quat_q [4];
	logic signed [31:0] org_q [3];
	logic signed [31:0] axis_q [9];
	logic signed [31:0] op_q [4];
	logic signed [31:0] ham_q [4];
	logic signed [31:0] res_q [4];
	logic [2:0] mode_q;
	logic [3:0] ent_q;
	logic [2:0] trm_q;
	logic signed [40:0] acc_q;
	logic out_valid_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic [4:0] shamt;
	logic neg, cst, last;
	logic signed [40:0] term, acc_n, fin;
	logic [2:0] nterm;
	logic [2:0] in_mode;
	logic signed [31:0] in_op [4];

	assign in_mode = s_axis_tdata[2:0];
	assign in_op[0] = s_axis_tdata[34:3];
	assign in_op[1] = s_axis_tdata[66:35];
	assign in_op[2] = s_axis_tdata[98:67];
	assign in_op[3] = s_axis_tdata[130:99];

	assign s_axis_tready = (state_q == qft_pkg::ST_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {res_q[3], res_q[2], res_q[1], res_q[0]};

	// operand select for one term of one entry
	always_comb begin
		ma = '0;
		mb = '0;
		neg = 1'b0;
		cst = 1'b0;
		shamt = 5'd28;
		nterm = 3'd3;
		unique case (state_q)
			qft_pkg::ST_HAM: begin
				nterm = 3'd4;
				case (ent_q[1:0])
					2'd0: begin
						case (trm_q[1:0])
							2'd0: begin ma = quat_q[0]; mb = op_q[0]; end
							2'd1: begin ma = quat_q[1]; mb = op_q[1]; neg = 1'b1; end
							2'd2: begin ma = quat_q[2]; mb = op_q[2]; neg = 1'b1; end
							default: begin ma = quat_q[3]; mb = op_q[3]; neg = 1'b1; end
						endcase
					end
					2'd1: begin
						case (trm_q[1:0])
							2'd0: begin ma = quat_q[0]; mb = op_q[1]; end
							2'd1: begin ma = quat_q[1]; mb = op_q[0]; end
							2'd2: begin ma = quat_q[2]; mb = op_q[3]; end
							default: begin ma = quat_q[3]; mb = op_q[2]; neg = 1'b1; end
						endcase
					end
					2'd2: begin
						case (trm_q[1:0])
							2'd0: begin ma = quat_q[0]; mb = op_q[2]; end
							2'd1: begin ma = quat_q[1]; mb = op_q[3]; neg = 1'b1; end
							2'd2: begin ma = quat_q[2]; mb = op_q[0]; end
							default: begin ma = quat_q[3]; mb = op_q[1]; end
						endcase
					end
					default: begin
						case (trm_q[1:0])
							2'd0: begin ma = quat_q[0]; mb = op_q[3]; end
							2'd1: begin ma = quat_q[1]; mb = op_q[2]; end
							2'd2: begin ma = quat_q[2]; mb = op_q[1]; neg = 1'b1; end
							default: begin ma = quat_q[3]; mb = op_q[0]; end
						endcase
					end
				endcase
			end
			qft_pkg::ST_AXIS: begin
				shamt = 5'd27;
				// quat_q: 0 w, 1 x, 2 y, 3 z
				case (ent_q)
					4'd0, 4'd4, 4'd8: begin
						cst = (trm_q == 3'd0);
						neg = 1'b1;
						case (ent_q)
							4'd0: begin
								ma = (trm_q == 3'd1) ? quat_q[2] : quat_q[3];
							end
							4'd4: begin
								ma = (trm_q == 3'd1) ? quat_q[1] : quat_q[3];
							end
							default: begin
								ma = (trm_q == 3'd1) ? quat_q[2] : quat_q[1];
							end
						endcase
						mb = ma;
					end
					4'd1, 4'd3: begin
						nterm = 3'd2;
						ma = (trm_q == 3'd0) ? quat_q[1] : quat_q[3];
						mb = (trm_q == 3'd0) ? quat_q[2] : quat_q[0];
						neg = (ent_q == 4'd3) && (trm_q == 3'd1);
					end
					4'd2, 4'd6: begin
						nterm = 3'd2;
						ma = (trm_q == 3'd0) ? quat_q[1] : quat_q[2];
						mb = (trm_q == 3'd0) ? quat_q[3] : quat_q[0];
						neg = (ent_q == 4'd2) && (trm_q == 3'd1);
					end
					default: begin
						nterm = 3'd2;
						ma = (trm_q == 3'd0) ? quat_q[2] : quat_q[1];
						mb = (trm_q == 3'd0) ? quat_q[3] : quat_q[0];
						neg = (ent_q == 4'd7) && (trm_q == 3'd1);
					end
				endcase
			end
			qft_pkg::ST_VEC: begin
				ma = op_q[trm_q[1:0] + 2'd1];
				if (mode_q == qft_pkg::MODE_TO_LOCAL) begin
					mb = axis_q[4'(ent_q * 3) + 4'(trm_q)];
				end else begin
					mb = axis_q[4'(trm_q * 3) + ent_q];
				end
			end
			default: begin
			end
		endcase
	end

	assign prod = ma * mb;
	always_comb begin
		logic signed [63:0] rp;
		rp = (prod + (64'sd1 <<< (shamt - 5'd1))) >>> shamt;
		if (cst) begin
			term = 41'sd4294967296;
		end else if (neg) begin
			term = -rp[40:0];
		end else begin
			term = rp[40:0];
		end
	end
	assign acc_n = acc_q + term;
	assign last = (trm_q == nterm - 3'd1);
	assign fin = (acc_n + 41'sd2) >>> 2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qft_pkg::ST_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					case (qft_pkg::mode_t'(in_mode))
						qft_pkg::MODE_SET_ORIENT: state_d = qft_pkg::ST_AXIS;
						qft_pkg::MODE_ROTATE: state_d = qft_pkg::ST_HAM;
						qft_pkg::MODE_TO_LOCAL, qft_pkg::MODE_TO_GLOBAL: state_d = qft_pkg::ST_VEC;
						qft_pkg::MODE_READ_ORIENT, qft_pkg::MODE_READ_ORIGIN: state_d = qft_pkg::ST_OUT;
						default: state_d = qft_pkg::ST_IDLE;
					endcase
				end
			end
			qft_pkg::ST_HAM: if (last && ent_q == 4'd3) state_d = qft_pkg::ST_HAM_WB;
			qft_pkg::ST_HAM_WB: state_d = qft_pkg::ST_AXIS;
			qft_pkg::ST_AXIS: if (last && ent_q == 4'd8) state_d = qft_pkg::ST_AXIS_WB;
			qft_pkg::ST_AXIS_WB: state_d = qft_pkg::ST_IDLE;
			qft_pkg::ST_VEC: if (last && ent_q == 4'd2) state_d = qft_pkg::ST_VEC_WB;
			qft_pkg::ST_VEC_WB: state_d = qft_pkg::ST_IDLE;
			qft_pkg::ST_OUT: state_d = qft_pkg::ST_IDLE;
			default: state_d = qft_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qft_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			ent_q <= '0;
			trm_q <= '0;
			acc_q <= '0;
			quat_q <= '{qft_pkg::OneQ30, '0, '0, '0};
			org_q <= '{'0, '0, '0};
			axis_q <= '{qft_pkg::OneQ30, '0, '0, '0, qft_pkg::OneQ30, '0, '0, '0,
				qft_pkg::OneQ30};
		end else begin
			state_q <= state_d;
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				qft_pkg::ST_IDLE: begin
					ent_q <= '0;
					trm_q <= '0;
					acc_q <= '0;
					if (s_axis_tvalid && s_axis_tready) begin
						mode_q <= in_mode;
						op_q <= in_op;
						case (qft_pkg::mode_t'(in_mode))
							qft_pkg::MODE_SET_ORIENT: quat_q <= in_op;
							qft_pkg::MODE_SET_ORIGIN: org_q <= in_op[1:3];
							qft_pkg::MODE_TRANSLATE: begin
								for (int i = 0; i < 3; i++) begin
									org_q[i] <= qft_pkg::sat32(41'(org_q[i]) + 41'(in_op[i+1]));
								end
							end
							default: begin
							end
						endcase
					end
				end
				qft_pkg::ST_HAM, qft_pkg::ST_AXIS, qft_pkg::ST_VEC: begin
					if (last) begin
						trm_q <= '0;
						acc_q <= '0;
						ent_q <= ent_q + 4'd1;
						if (state_q == qft_pkg::ST_HAM) ham_q[ent_q[1:0]] <= qft_pkg::sat32(fin);
						else if (state_q == qft_pkg::ST_AXIS) axis_q[ent_q] <= qft_pkg::sat32(fin);
						else res_q[ent_q[1:0] + 2'd1] <= qft_pkg::sat32(fin);
					end else begin
						trm_q <= trm_q + 3'd1;
						acc_q <= acc_n;
					end
				end
				qft_pkg::ST_HAM_WB: begin
					quat_q <= ham_q;
					ent_q <= '0;
				end
				qft_pkg::ST_VEC_WB: begin
					res_q[0] <= '0;
					out_valid_q <= 1'b1;
				end
				qft_pkg::ST_OUT: begin
					if (mode_q == qft_pkg::MODE_READ_ORIENT) begin
						res_q <= quat_q;
					end else begin
						res_q <= '{'0, org_q[0], org_q[1], org_q[2]};
					end
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/qft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_checker
// port-level checks for the frame transform
// ----------------------------------------------------------------------------
module qft_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [qft_pkg::InTdataW-1:0]  s_axis_tdata,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [qft_pkg::OutTdataW-1:0] m_axis_tdata
);

	// no new word while a result waits
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");

	// busy after an accepted word that needs the multiplier or gives a result
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready
			&& qft_pkg::mode_t'(s_axis_tdata[2:0]) != qft_pkg::MODE_SET_ORIGIN
			&& qft_pkg::mode_t'(s_axis_tdata[2:0]) != qft_pkg::MODE_TRANSLATE)
		|=> !s_axis_tready) else $error("ready after accept");

	// result held while stalled
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// result valid rises only after the input side was not ready
	a_out_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready)) else $error("spurious result");

endmodule

bind quaternion_frame_transform qft_checker u_qft_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for quaternion_frame_transform: a directed table then
// random pose updates and transforms, each accepted word run through a local
// fixed-point frame model; results compared in order with random back-pressure
// ----------------------------------------------------------------------------
module tb;

	typedef logic signed [31:0] s32_t;

	typedef struct {
		s32_t w, x, y, z;
	} quad_t;

	typedef struct {
		qft_pkg::mode_t m;
		s32_t w, x, y, z;
		bit typed;
		quad_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [135:0] s_axis_tdata = '0;   // mode[2:0], op_w, op_x, op_y, op_z
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;        // res_w, res_x, res_y, res_z

	quad_t result_fifo[$];
	longint frame_q[4];
	longint frame_org[3];
	longint frame_axis[9];
	bit failed = 1'b0;
	bit calm = 1'b0;

	quaternion_frame_transform i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint rnd_hu(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint twice_q(longint a, longint b);
		return rnd_hu(a * b, 27);
	endfunction

	function automatic longint mul_q(longint a, longint b);
		return rnd_hu(a * b, 28);
	endfunction

	function automatic longint dot_vec(longint v0, longint v1, longint v2,
			longint e0, longint e1, longint e2);
		return clamp32(rnd_hu(mul_q(v0, e0) + mul_q(v1, e1) + mul_q(v2, e2), 2));
	endfunction

	function automatic void frame_reset();
		frame_q = '{64'sd1073741824, 0, 0, 0};
		frame_org = '{0, 0, 0};
		for (int i = 0; i < 9; i++) begin
			frame_axis[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
		end
	endfunction

	function automatic void derive_axes();
		longint w, x, y, z, one;
		longint t[9];
		w = frame_q[0]; x = frame_q[1]; y = frame_q[2]; z = frame_q[3];
		one = 64'sd4294967296;
		t[0] = one - twice_q(y, y) - twice_q(z, z);
		t[1] = twice_q(x, y) + twice_q(z, w);
		t[2] = twice_q(x, z) - twice_q(y, w);
		t[3] = twice_q(x, y) - twice_q(z, w);
		t[4] = one - twice_q(x, x) - twice_q(z, z);
		t[5] = twice_q(y, z) + twice_q(x, w);
		t[6] = twice_q(x, z) + twice_q(y, w);
		t[7] = twice_q(y, z) - twice_q(x, w);
		t[8] = one - twice_q(y, y) - twice_q(x, x);
		for (int i = 0; i < 9; i++) begin
			frame_axis[i] = clamp32(rnd_hu(t[i], 2));
		end
	endfunction

	// returns 1 when the word produces a result
	function automatic bit frame_step(qft_pkg::mode_t m, s32_t w, s32_t x, s32_t y,
			s32_t z, output quad_t r);
		longint a[4];
		longint b[4];
		longint p[4];
		a = frame_q;
		b = '{w, x, y, z};
		r = '{0, 0, 0, 0};
		case (m)
			qft_pkg::MODE_SET_ORIENT: begin
				frame_q = b;
				derive_axes();
				return 0;
			end
			qft_pkg::MODE_SET_ORIGIN: begin
				frame_org = '{x, y, z};
				return 0;
			end
			qft_pkg::MODE_ROTATE: begin
				p[0] = mul_q(a[0], b[0]) - mul_q(a[1], b[1]) - mul_q(a[2], b[2])
					- mul_q(a[3], b[3]);
				p[1] = mul_q(a[0], b[1]) + mul_q(a[1], b[0]) + mul_q(a[2], b[3])
					- mul_q(a[3], b[2]);
				p[2] = mul_q(a[0], b[2]) - mul_q(a[1], b[3]) + mul_q(a[2], b[0])
					+ mul_q(a[3], b[1]);
				p[3] = mul_q(a[0], b[3]) + mul_q(a[1], b[2]) - mul_q(a[2], b[1])
					+ mul_q(a[3], b[0]);
				for (int i = 0; i < 4; i++) begin
					frame_q[i] = clamp32(rnd_hu(p[i], 2));
				end
				derive_axes();
				return 0;
			end
			qft_pkg::MODE_TRANSLATE: begin
				frame_org[0] = clamp32(frame_org[0] + x);
				frame_org[1] = clamp32(frame_org[1] + y);
				frame_org[2] = clamp32(frame_org[2] + z);
				return 0;
			end
			qft_pkg::MODE_TO_LOCAL: begin
				r.x = dot_vec(x, y, z, frame_axis[0], frame_axis[1], frame_axis[2]);
				r.y = dot_vec(x, y, z, frame_axis[3], frame_axis[4], frame_axis[5]);
				r.z = dot_vec(x, y, z, frame_axis[6], frame_axis[7], frame_axis[8]);
			end
			qft_pkg::MODE_TO_GLOBAL: begin
				r.x = dot_vec(x, y, z, frame_axis[0], frame_axis[3], frame_axis[6]);
				r.y = dot_vec(x, y, z, frame_axis[1], frame_axis[4], frame_axis[7]);
				r.z = dot_vec(x, y, z, frame_axis[2], frame_axis[5], frame_axis[8]);
			end
			qft_pkg::MODE_READ_ORIENT: begin
				r = '{frame_q[0], frame_q[1], frame_q[2], frame_q[3]};
			end
			default: begin
				r = '{0, frame_org[0], frame_org[1], frame_org[2]};
			end
		endcase
		return 1;
	endfunction

	task automatic send_word(qft_pkg::mode_t m, s32_t w, s32_t x, s32_t y, s32_t z,
			bit typed, quad_t want);
		quad_t r;
		bit has;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, z, y, x, w, m};
		do @(posedge clk); while (!s_axis_tready);
		has = frame_step(m, w, x, y, z, r);
		if (has) begin
			result_fifo.push_back(typed ? want : r);
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic s32_t rand_op(bit quat);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return quat ? 32'sh4000_0000 : 32'sh7fff_ffff;
			2: return quat ? -32'sh4000_0000 : 32'sh8000_0000;
			default: return quat ? s32_t'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000
				: s32_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	localparam s32_t C45 = 32'sh2D41_3CCD;

	row_t dir_rows[] = '{
		'{qft_pkg::MODE_READ_ORIENT, 0, 0, 0, 0, 1, '{32'sh4000_0000, 0, 0, 0}},
		'{qft_pkg::MODE_READ_ORIGIN, -1, -1, -1, -1, 1, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_TO_LOCAL, 5, 32'sh7fff_ffff, 32'sh8000_0000, 1, 1,
			'{0, 32'sh7fff_ffff, 32'sh8000_0000, 1}},
		'{qft_pkg::MODE_TO_GLOBAL, 0, 32'sh8000_0000, 32'sh7fff_ffff, -1, 1,
			'{0, 32'sh8000_0000, 32'sh7fff_ffff, -1}},
		'{qft_pkg::MODE_SET_ORIGIN, -1, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0,
			'{0, 0, 0, 0}},
		'{qft_pkg::MODE_TRANSLATE, -1, 1, -1, 5, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_READ_ORIGIN, 0, 0, 0, 0, 1,
			'{0, 32'sh7fff_ffff, 32'sh8000_0000, 5}},
		'{qft_pkg::MODE_SET_ORIENT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_READ_ORIENT, 0, 0, 0, 0, 1, '{32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000}},
		'{qft_pkg::MODE_TO_LOCAL, 0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 0,
			'{0, 0, 0, 0}},
		'{qft_pkg::MODE_SET_ORIENT, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_TO_GLOBAL, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0,
			'{0, 0, 0, 0}},
		'{qft_pkg::MODE_SET_ORIENT, C45, 0, 0, C45, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_ROTATE, C45, C45, 0, 0, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_READ_ORIENT, 0, 0, 0, 0, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_TO_LOCAL, 0, 32'sh0001_0000, 0, 0, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_TO_GLOBAL, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0,
			'{0, 0, 0, 0}},
		'{qft_pkg::MODE_ROTATE, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh7fff_ffff, 0, '{0, 0, 0, 0}},
		'{qft_pkg::MODE_READ_ORIENT, 0, 0, 0, 0, 0, '{0, 0, 0, 0}}
	};

	// result side: stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		quad_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
				m_axis_tdata[127:96]};
			if (result_fifo.size() == 0) begin
				$display("%0t: unexpected word w=%h x=%h y=%h z=%h", $time,
					got.w, got.x, got.y, got.z);
				failed = 1'b1;
			end else begin
				want = result_fifo.pop_front();
				if (got.w !== want.w) begin
					$display("%0t: res_w expected %h got %h", $time, want.w, got.w);
					failed = 1'b1;
				end
				if (got.x !== want.x) begin
					$display("%0t: res_x expected %h got %h", $time, want.x, got.x);
					failed = 1'b1;
				end
				if (got.y !== want.y) begin
					$display("%0t: res_y expected %h got %h", $time, want.y, got.y);
					failed = 1'b1;
				end
				if (got.z !== want.z) begin
					$display("%0t: res_z expected %h got %h", $time, want.z, got.z);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		quad_t none;
		qft_pkg::mode_t m;
		int n;
		none = '{0, 0, 0, 0};
		frame_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].m, dir_rows[i].w, dir_rows[i].x, dir_rows[i].y,
				dir_rows[i].z, dir_rows[i].typed, dir_rows[i].want);
		end
		n = 1330;
		for (int i = 0; i < n; i++) begin
			if (i == n - 150) calm = 1'b1;
			m = qft_pkg::mode_t'($urandom_range(0, 7));
			if (m == qft_pkg::MODE_SET_ORIENT || m == qft_pkg::MODE_ROTATE) begin
				send_word(m, rand_op(1), rand_op(1), rand_op(1), rand_op(1), 0, none);
			end else begin
				send_word(m, $urandom, rand_op(0), rand_op(0), rand_op(0), 0, none);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (!failed) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/qft_pkg.sv
sv/quaternion_frame_transform.sv
sv/qft_checker.sv
tb/tb.sv
